FILE: hw/rtl/nalsc_pkg.sv
// Shared types and constants of the length-prefixed NAL to start-code converter.
package nalsc_pkg;

    // Parser phase inside a packet
    typedef enum logic [1:0] {
        PH_LEN,
        PH_PAY,
        PH_DROP
    } t_phase;

    // Work handed from the parser to the emitter
    typedef enum logic [1:0] {
        CMD_START,
        CMD_PAY,
        CMD_ERR_LEN,
        CMD_ERR_TRUNC
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic        pend;
    } t_cmd;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LEN   = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // Start code 00 00 01
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // Index of the last byte of a 4-byte length field
    localparam logic [1:0] LEN_LAST_IDX = 2'd3;

    // Index of the last start-code byte
    localparam logic [1:0] SC_LAST_IDX = 2'd2;

    // Width of the packet length port
    localparam int PKT_PORT_W = 24;

    // Command queue
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

endpackage

FILE: hw/rtl/length_prefixed_nal_to_start_codes.sv
// Top level of the length-prefixed NAL to start-code converter.
// Converts packets of NAL units, each led by a 4-byte big-endian length, into start-code
// form. One byte is taken per transaction on the input queue interface (push/full); the
// packet length is sampled with each packet's first byte. The fourth byte of every length
// field yields the three results 00 00 01, payload bytes pass through one for one, and
// length bytes 1 to 3 yield nothing. A unit length that runs past the packet end gives a
// single result with status 1, a packet ending inside a length field gives one with
// status 2; the rest of that packet is then dropped. Results already delivered stand, so
// the consumer discards any packet that ends in an error. Rate: one input byte per cycle
// while the queue has room, one result per cycle while the consumer pops. The front parser
// takes a byte every cycle while the 4-entry command queue has room; the back emitter
// drains one result per cycle, so each start code holds the emitter for three results and,
// if the queue fills, stalls input through full. A taken byte's command enters the queue,
// then its result enters the output register. No clearing pass is needed after reset.
module length_prefixed_nal_to_start_codes #(
    parameter int PACKET_SIZE_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       i_data_byte,
    input  logic [nalsc_pkg::PKT_PORT_W-1:0] i_packet_bytes,
    output logic                             empty,
    input  logic                             pop,
    output logic [7:0]                       o_out_byte,
    output logic                             o_item_last,
    output logic                             o_packet_end,
    output logic [1:0]                       o_status
);
    import nalsc_pkg::*;

    logic  accept;
    logic  cmd_wr;
    t_cmd  cmd_in;
    t_cmd  cmd_head;
    logic  q_rd;
    logic  q_empty;
    logic  q_full;

    // take a byte whenever the command queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    nalsc_front #(
        .PACKET_SIZE_BITS(PACKET_SIZE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_packet_bytes (i_packet_bytes),
        .o_cmd_wr       (cmd_wr),
        .o_cmd          (cmd_in)
    );

    // hold classified work until the emitter can take it
    nalsc_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_wr),
        .i_wr_cmd (cmd_in),
        .i_rd     (q_rd),
        .o_rd_cmd (cmd_head),
        .o_empty  (q_empty),
        .o_full   (q_full)
    );

    // expand commands into result transactions
    nalsc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_cmd      (cmd_head),
        .o_q_rd       (q_rd),
        .pop          (pop),
        .empty        (empty),
        .o_out_byte   (o_out_byte),
        .o_item_last  (o_item_last),
        .o_packet_end (o_packet_end),
        .o_status     (o_status)
    );

endmodule

FILE: hw/rtl/nalsc_front.sv
// Front end: parses length fields and classifies each input byte into a command.
module nalsc_front #(
    parameter int PACKET_SIZE_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [7:0]                       i_data_byte,
    input  logic [nalsc_pkg::PKT_PORT_W-1:0] i_packet_bytes,
    output logic                             o_cmd_wr,
    output nalsc_pkg::t_cmd                  o_cmd
);
    import nalsc_pkg::*;

    localparam int PKT_W = (PACKET_SIZE_BITS < PKT_PORT_W) ? PACKET_SIZE_BITS : PKT_PORT_W;

    t_phase             r_phase, n_phase, cur_phase;
    logic [1:0]         r_cnt, n_cnt, cur_cnt;
    logic [23:0]        r_acc, n_acc, cur_acc;
    logic [PKT_W-1:0]   r_pay, n_pay, cur_pay;
    logic [PKT_W-1:0]   r_left, n_left, cur_left;
    logic [PKT_W-1:0]   size_in;
    logic [PKT_W-1:0]   rem;
    logic [31:0]        len;
    logic               pend;
    logic               emit;

    always_comb begin
        cur_phase = r_phase;
        cur_cnt   = r_cnt;
        cur_acc   = r_acc;
        cur_pay   = r_pay;
        cur_left  = r_left;
        size_in   = i_packet_bytes[PKT_W-1:0];
        // sample the packet length on its first byte
        if (r_left == '0) begin
            cur_left  = (size_in == '0) ? PKT_W'(1) : size_in;
            cur_phase = PH_LEN;
            cur_cnt   = '0;
            cur_acc   = '0;
            cur_pay   = '0;
        end
        rem  = cur_left - PKT_W'(1);
        pend = (rem == '0);
        len  = {cur_acc, i_data_byte};

        n_phase = cur_phase;
        n_cnt   = cur_cnt;
        n_acc   = cur_acc;
        n_pay   = cur_pay;
        n_left  = rem;
        emit    = 1'b0;
        o_cmd   = '{kind: CMD_PAY, data: i_data_byte, pend: pend};

        case (cur_phase)
            PH_LEN: begin
                if (cur_cnt == LEN_LAST_IDX) begin
                    n_cnt = '0;
                    n_acc = '0;
                    emit  = 1'b1;
                    if (len > 32'(rem)) begin
                        n_phase    = PH_DROP;
                        o_cmd.kind = CMD_ERR_LEN;
                    end else begin
                        o_cmd.kind = CMD_START;
                        if (len == '0) begin
                            n_phase = PH_LEN;
                        end else begin
                            n_phase = PH_PAY;
                            n_pay   = len[PKT_W-1:0];
                        end
                    end
                end else begin
                    n_cnt = cur_cnt + 2'd1;
                    n_acc = {cur_acc[15:0], i_data_byte};
                    if (pend) begin
                        // packet ends inside the length field
                        n_phase    = PH_DROP;
                        n_cnt      = '0;
                        n_acc      = '0;
                        emit       = 1'b1;
                        o_cmd.kind = CMD_ERR_TRUNC;
                    end
                end
            end
            PH_PAY: begin
                emit = 1'b1;
                if (cur_pay != '0) begin
                    n_pay = cur_pay - PKT_W'(1);
                end
                if (n_pay == '0) begin
                    n_phase = PH_LEN;
                    n_cnt   = '0;
                    n_acc   = '0;
                end
            end
            default: begin
                // drop until the packet ends
            end
        endcase
        o_cmd_wr = i_accept && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_pay   <= '0;
            r_left  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_pay   <= n_pay;
            r_left  <= n_left;
        end
    end

endmodule

FILE: hw/rtl/nalsc_cmdq.sv
// Short command queue between the parser and the emitter.
module nalsc_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  nalsc_pkg::t_cmd i_wr_cmd,
    input  logic            i_rd,
    output nalsc_pkg::t_cmd o_rd_cmd,
    output logic            o_empty,
    output logic            o_full
);
    import nalsc_pkg::*;

    t_cmd                r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  r_wr_ptr;
    logic [CMDQ_AW-1:0]  r_rd_ptr;
    logic [CMDQ_CW-1:0]  r_count;

    assign o_empty  = (r_count == '0);
    assign o_full   = (r_count == CMDQ_CW'(CMDQ_DEPTH));
    assign o_rd_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + CMDQ_AW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + CMDQ_AW'(1);
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + CMDQ_CW'(1);
                2'b01:   r_count <= r_count - CMDQ_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/nalsc_back.sv
// Back end: expands queued commands into result bytes behind an output register.
module nalsc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  nalsc_pkg::t_cmd i_q_cmd,
    output logic            o_q_rd,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      o_out_byte,
    output logic            o_item_last,
    output logic            o_packet_end,
    output logic [1:0]      o_status
);
    import nalsc_pkg::*;

    logic        r_valid;
    logic [1:0]  r_sub, n_sub;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic        r_pend, n_pend;
    logic [1:0]  r_st, n_st;
    logic        load;

    // refill the output register when it is free or being taken
    assign load = !i_q_empty && (!r_valid || pop);

    always_comb begin
        n_sub  = r_sub;
        n_byte = i_q_cmd.data;
        n_last = 1'b1;
        n_pend = i_q_cmd.pend;
        n_st   = ST_OK;
        o_q_rd = 1'b0;
        case (i_q_cmd.kind)
            CMD_START: begin
                if (r_sub == SC_LAST_IDX) begin
                    n_byte = SC_ONE;
                    n_sub  = '0;
                    o_q_rd = load;
                end else begin
                    n_byte = SC_ZERO;
                    n_last = 1'b0;
                    n_pend = 1'b0;
                    n_sub  = r_sub + 2'd1;
                end
            end
            CMD_PAY: begin
                o_q_rd = load;
            end
            CMD_ERR_LEN: begin
                n_byte = '0;
                n_pend = 1'b1;
                n_st   = ST_LEN;
                o_q_rd = load;
            end
            default: begin
                n_byte = '0;
                n_pend = 1'b1;
                n_st   = ST_TRUNC;
                o_q_rd = load;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= n_sub;
            end else if (pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_last <= n_last;
            r_pend <= n_pend;
            r_st   <= n_st;
        end
    end

    assign empty        = !r_valid;
    assign o_out_byte   = r_byte;
    assign o_item_last  = r_last;
    assign o_packet_end = r_pend;
    assign o_status     = r_st;

    a_sub_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != '0) |-> (!i_q_empty && i_q_cmd.kind == CMD_START))
        else $error("start-code expansion lost its command");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_st != ST_OK) |-> (r_byte == '0 && r_last && r_pend))
        else $error("error result malformed");

    a_pend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_pend) |-> r_last)
        else $error("packet end without item end");

endmodule

FILE: test/nalsc_checker.sv
// Checker for the NAL start-code converter: predicts the result stream and compares it.
module nalsc_checker #(
    parameter int PACKET_SIZE_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic                             i_full,
    input  logic [7:0]                       i_data_byte,
    input  logic [nalsc_pkg::PKT_PORT_W-1:0] i_packet_bytes,
    input  logic                             i_empty,
    input  logic                             i_pop,
    input  logic [7:0]                       i_out_byte,
    input  logic                             i_item_last,
    input  logic                             i_packet_end,
    input  logic [1:0]                       i_status,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);
    import nalsc_pkg::*;

    localparam logic [31:0] PKT_MASK     = (32'd1 << PACKET_SIZE_BITS) - 32'd1;
    localparam logic [7:0]  ERR_BYTE     = 8'h00;
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       item_last;
        logic       packet_end;
        logic [1:0] status;
    } t_nal_out;

    // Converted bytes still owed by the block, oldest first
    t_nal_out sc_out_q[$];

    // Predicted parser state
    t_phase      ph;
    logic [1:0]  len_idx;
    logic [31:0] len_acc;
    logic [31:0] unit_left;
    logic [31:0] pkt_left;

    int fails   = 0;
    int checked = 0;

    task automatic add_out(input logic [7:0] b, input logic last, input logic pend,
                           input logic [1:0] st);
        t_nal_out r;
        r.out_byte   = b;
        r.item_last  = last;
        r.packet_end = pend;
        r.status     = st;
        sc_out_q.push_back(r);
    endtask

    // Advance the parser by one accepted byte and queue what it emits
    task automatic convert_byte(input logic [7:0] b, input logic [PKT_PORT_W-1:0] pb);
        logic [31:0] rem;
        logic [31:0] unit_len;
        logic        pend;
        if (pkt_left == 32'd0) begin
            pkt_left = 32'(pb) & PKT_MASK;
            if (pkt_left == 32'd0) begin
                pkt_left = 32'd1;
            end
            ph        = PH_LEN;
            len_idx   = '0;
            len_acc   = '0;
            unit_left = '0;
        end
        rem      = pkt_left - 32'd1;
        pkt_left = rem;
        pend     = (rem == 32'd0);
        case (ph)
            PH_LEN: begin
                len_acc = {len_acc[23:0], b};
                if (len_idx == LEN_LAST_IDX) begin
                    unit_len = len_acc;
                    len_idx  = '0;
                    len_acc  = '0;
                    if (unit_len > rem) begin
                        ph = PH_DROP;
                        add_out(ERR_BYTE, 1'b1, 1'b1, ST_LEN);
                    end else begin
                        add_out(SC_ZERO, 1'b0, 1'b0, ST_OK);
                        add_out(SC_ZERO, 1'b0, 1'b0, ST_OK);
                        add_out(SC_ONE, 1'b1, pend, ST_OK);
                        if (unit_len == 32'd0) begin
                            ph = PH_LEN;
                        end else begin
                            ph        = PH_PAY;
                            unit_left = unit_len;
                        end
                    end
                end else begin
                    len_idx = len_idx + 2'd1;
                    if (rem == 32'd0) begin
                        ph      = PH_DROP;
                        len_idx = '0;
                        len_acc = '0;
                        add_out(ERR_BYTE, 1'b1, 1'b1, ST_TRUNC);
                    end
                end
            end
            PH_PAY: begin
                add_out(b, 1'b1, pend, ST_OK);
                if (unit_left != 32'd0) begin
                    unit_left = unit_left - 32'd1;
                end
                if (unit_left == 32'd0) begin
                    ph      = PH_LEN;
                    len_idx = '0;
                    len_acc = '0;
                end
            end
            default: begin
                // drop until the packet ends
            end
        endcase
    endtask

    task automatic report(input string what, input t_nal_out want, input t_nal_out got);
        fails++;
        if (fails <= REPORT_LIMIT) begin
            $display("%0t %s: expected %02h/%0d/%0d/%0d, got %02h/%0d/%0d/%0d",
                     $time, what, want.out_byte, want.item_last, want.packet_end, want.status,
                     got.out_byte, got.item_last, got.packet_end, got.status);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_nal_out got;
        t_nal_out want;
        if (!i_rst_n) begin
            ph        = PH_LEN;
            len_idx   = '0;
            len_acc   = '0;
            unit_left = '0;
            pkt_left  = '0;
            sc_out_q.delete();
        end else begin
            // Check the output transaction first: a byte taken now cannot be on the output yet
            if (i_pop && !i_empty) begin
                got.out_byte   = i_out_byte;
                got.item_last  = i_item_last;
                got.packet_end = i_packet_end;
                got.status     = i_status;
                if (sc_out_q.size() == 0) begin
                    report("result with nothing pending", '0, got);
                end else begin
                    want = sc_out_q.pop_front();
                    checked++;
                    if (got != want) begin
                        report("result mismatch", want, got);
                    end
                end
            end
            if (i_push && !i_full) begin
                convert_byte(i_data_byte, i_packet_bytes);
            end
        end
        o_fail_count <= fails;
        o_pending    <= sc_out_q.size();
        o_checked    <= checked;
    end

endmodule

FILE: test/tb_top.sv
// Testbench top for the length-prefixed NAL to start-code converter.
module tb_top;
    import nalsc_pkg::*;

    localparam int RANDOM_BYTES = 75;
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off to back up the block
    localparam int STALL_LIMIT  = 1000;  // cycles without any transaction before giving up
    localparam int TAIL_CYCLES  = 16;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  push           = 1'b0;
    logic                  pop            = 1'b0;
    logic [7:0]            i_data_byte    = '0;
    logic [PKT_PORT_W-1:0] i_packet_bytes = '0;
    logic                  full;
    logic                  empty;
    logic [7:0]            o_out_byte;
    logic                  o_item_last;
    logic                  o_packet_end;
    logic [1:0]            o_status;

    int fail_count;
    int pending;
    int checked;

    // Bytes of the packet being sent, and run statistics
    logic [7:0]  pkt_q[$];
    int unsigned bytes_sent   = 0;
    int unsigned packets_sent = 0;
    int unsigned quiet_cycles = 0;

    // Drop all idling on both sides while set
    bit steady   = 1'b0;
    // Ask the receiver for one long hold-off
    bit hold_req = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    length_prefixed_nal_to_start_codes uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_packet_bytes (i_packet_bytes),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_item_last    (o_item_last),
        .o_packet_end   (o_packet_end),
        .o_status       (o_status)
    );

    nalsc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_data_byte    (i_data_byte),
        .i_packet_bytes (i_packet_bytes),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_out_byte     (o_out_byte),
        .i_item_last    (o_item_last),
        .i_packet_end   (o_packet_end),
        .i_status       (o_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Unit length: mostly small, sometimes a few dozen bytes
    function automatic int unsigned pick_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(7, 40);
        end
        return $urandom_range(0, 6);
    endfunction

    // Append one NAL unit: 4-byte big-endian length, then random payload
    task automatic add_unit(input int unsigned len);
        logic [31:0] l;
        l = len;
        pkt_q.push_back(l[31:24]);
        pkt_q.push_back(l[23:16]);
        pkt_q.push_back(l[15:8]);
        pkt_q.push_back(l[7:0]);
        repeat (len) pkt_q.push_back(8'($urandom));
    endtask

    // Offer one byte and hold it until the input transaction completes.
    // Lower push only when a gap follows, so push never toggles within one step.
    task automatic send_byte(input logic [7:0] b, input logic [PKT_PORT_W-1:0] pb);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_data_byte    <= b;
        i_packet_bytes <= pb;
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    // Send pkt_q as one packet. The count only matters on the first byte; the rest carry
    // random junk there, which the block must ignore.
    task automatic send_packet(input logic [PKT_PORT_W-1:0] plen);
        int i;
        for (i = 0; i < pkt_q.size(); i++) begin
            send_byte(pkt_q[i], (i == 0) ? plen : PKT_PORT_W'($urandom));
        end
        packets_sent++;
    endtask

    // Receiver: random pop bursts and gaps, plus one long hold-off on request.
    // pop is assigned at most once per step: it is lowered only when a real gap follows.
    initial begin : drain
        int unsigned gap;
        repeat (7) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = pick_gap();
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Count cycles in which neither side completes a transaction
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("length_prefixed_nal_to_start_codes: mismatch");
        $finish;
    end

    initial begin : stimulus
        int unsigned kind;
        int unsigned directed_bytes;
        int unsigned cut;
        int unsigned rand_sent;

        // Hold reset, then release it once for good
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero packet count acts as one: a lone length byte is a truncation
        pkt_q = '{8'hFF};
        send_packet(24'd0);
        // Unit that exactly fills the packet; payload at both byte extremes
        pkt_q = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00};
        send_packet(24'd6);
        // Zero-length unit closing the packet on the start code
        pkt_q = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_packet(24'd4);
        // Unit longer than the packet, then one dropped byte
        pkt_q = '{8'h00, 8'h00, 8'h00, 8'h05, 8'h3C};
        send_packet(24'd5);
        // Packet ending after two length bytes
        pkt_q = '{8'h00, 8'h00};
        send_packet(24'd2);
        // Length with its top bit set
        pkt_q = '{8'h80, 8'h00, 8'h00, 8'h00};
        send_packet(24'd4);
        directed_bytes = bytes_sent;

        // Back the block up right away: the receiver holds off while bytes keep coming
        hold_req = 1'b1;

        rand_sent = 0;
        while (rand_sent < RANDOM_BYTES) begin
            // Run a middle stretch with no idling on either side
            steady = (rand_sent >= 45) && (rand_sent < 70);
            pkt_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                repeat ($urandom_range(1, 3)) add_unit(pick_len());
                if (kind >= 70) begin
                    // Break the packet: cut it short or garble the first length
                    if ($urandom_range(0, 1) == 0) begin
                        cut = $urandom_range(1, pkt_q.size() - 1);
                        while (pkt_q.size() > cut) void'(pkt_q.pop_back());
                    end else begin
                        pkt_q[0] = 8'($urandom_range(1, 255));
                    end
                end
            end else begin
                // Noise: a short packet of random bytes
                repeat ($urandom_range(1, 8)) pkt_q.push_back(8'($urandom));
            end
            send_packet(PKT_PORT_W'(pkt_q.size()));
            rand_sent = bytes_sent - directed_bytes;
        end
        steady = 1'b0;

        // Close with an all-ones packet count: one good unit, then a top-bit length error
        // and dropped bytes; the packet stays open at the end of the run
        pkt_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h7E, 8'h80, 8'h00, 8'h00, 8'h00,
                  8'hFF, 8'hFF};
        send_packet(24'hFFFFFF);
        push <= 1'b0;

        // Step once so the pending count includes the last byte, then drain
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes in %0d packets: start codes, payload, zero-length units,",
                 bytes_sent, packets_sent);
        $display("length errors, truncations and drops; %0d results compared", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("length_prefixed_nal_to_start_codes: match");
        end else begin
            $display("length_prefixed_nal_to_start_codes: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/nalsc_pkg.sv
hw/rtl/nalsc_front.sv
hw/rtl/nalsc_cmdq.sv
hw/rtl/nalsc_back.sv
hw/rtl/length_prefixed_nal_to_start_codes.sv
test/nalsc_checker.sv
test/tb_top.sv
